### rtl/pcxrle_pkg.sv
// Shared types, constants and helper functions for the PCX RLE pixel decoder.
// No dependencies; imported by every other file of the block.
`default_nettype none

package pcxrle_pkg;

	localparam int BYTE_W     = 8;
	localparam int COL_W      = 16;
	localparam int ROW_W      = 11;
	localparam int RUN_W      = 6;
	localparam int LIM_W      = 15;
	localparam int SIZE_W     = 11;
	localparam int START_W    = 10;
	localparam int PIX_ADDR_W = 20;
	localparam int PROD_W     = 2 * SIZE_W;
	localparam int SUM_W      = 24;

	localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
	localparam logic [BYTE_W-1:0] RUN_MASK = 8'h3F;

	// APB register file
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LAST_COLUMN  = 3'd0,
		REG_LAST_ROW     = 3'd1,
		REG_LINE_WIDTH   = 3'd2,
		REG_FRAME_HEIGHT = 3'd3,
		REG_START_ROW    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LIM_W-1:0]   last_column;
		logic [LIM_W-1:0]   last_row;
		logic [SIZE_W-1:0]  line_width;
		logic [SIZE_W-1:0]  frame_height;
		logic [START_W-1:0] start_row;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic emit;        // load one pixel into the output register
		logic from_run;    // pixel value comes from the held run byte
		logic last;        // final pixel of the item: run wrap/end checks
		logic check;       // wrap/end checks without a pixel (empty run)
		logic set_pending; // run header seen, latch count
		logic load_run;    // run data byte seen, latch value
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic finished;
		logic pending;
		logic header;
		logic run_zero;
		logic run_one;
		logic slot_free;
	} dp_status_t;

	function automatic logic is_run_header(input logic [BYTE_W-1:0] b);
		return (b & RUN_MARK) == RUN_MARK;
	endfunction

	// hi, or size when hi > size-1; a zero size gives zero
	function automatic logic [LIM_W-1:0] clamp_limit(input logic [LIM_W-1:0] hi,
			input logic [SIZE_W-1:0] size);
		logic [LIM_W-1:0] size_x;
		size_x = {{(LIM_W-SIZE_W){1'b0}}, size};
		if (size == '0)
			return '0;
		else if (hi >= size_x)
			return size_x;
		else
			return hi;
	endfunction

endpackage

`default_nettype wire

### rtl/pcxrle_byte_if.sv
// Input channel of the PCX RLE decoder: one encoded byte per item.
// Depends on pcxrle_pkg.
`default_nettype none

interface pcxrle_byte_if;
	import pcxrle_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### rtl/pcxrle_pix_if.sv
// Output channel of the PCX RLE decoder: one frame buffer pixel write per item.
// Depends on pcxrle_pkg.
`default_nettype none

interface pcxrle_pix_if;
	import pcxrle_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIX_ADDR_W-1:0] pixel_address;
	logic [BYTE_W-1:0]     pixel_value;
	logic                  last_of_item;
	logic                  image_done;

	modport source (output valid, output pixel_address, output pixel_value,
		output last_of_item, output image_done, input ready);
	modport sink (input valid, input pixel_address, input pixel_value,
		input last_of_item, input image_done, output ready);
endinterface

`default_nettype wire

### rtl/pcx_rle_pixel_decoder.sv
// PCX 8-bit run-length pixel decoder, top level: register file, controller, datapath.
// Depends on pcxrle_pkg, pcxrle_byte_if, pcxrle_pix_if, pcxrle_cfg, pcxrle_ctrl, pcxrle_dp.
//
// Usage:
//   data_in   takes the encoded image stream one byte per item (valid/ready).
//   pixel_out gives one frame buffer write per item: address, palette index,
//             last_of_item on the final pixel of an input byte, image_done on
//             the final pixel of the byte that ends the image.
//   APB port  sets last_column, last_row, line_width, frame_height, start_row;
//             writing start_row reloads the row counter. Write only while idle.
// Timing:
//   A literal byte's pixel shows in the output register the cycle after the byte is taken.
//   A run header byte is taken, then the run data byte, and the run then holds
//   the input while the output register sends one pixel per cycle whenever the
//   receiver has taken the last one. The single output register sets the rate.
//   Once the image is done every input byte is taken and dropped.
// Reset: counters, run state and output valid clear; registers take defaults.
// Stall: a stalled receiver holds the output register and the input waits.
`default_nettype none

module pcx_rle_pixel_decoder #(
	parameter int ADDR_BITS = 20
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	pcxrle_byte_if.sink                            data_in,
	pcxrle_pix_if.source                           pixel_out,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pcxrle_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pcxrle_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [pcxrle_pkg::APB_DATA_W-1:0] prdata,
	output logic                                   pready
);
	import pcxrle_pkg::*;

	cfg_t               cfg;
	logic               row_load;
	logic [START_W-1:0] row_load_value;
	dp_cmd_t            cmd;
	dp_status_t         st;

	pcxrle_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.cfg            (cfg),
		.row_load       (row_load),
		.row_load_value (row_load_value)
	);

	pcxrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (data_in.valid),
		.in_ready (data_in.ready),
		.st       (st),
		.cmd      (cmd)
	);

	pcxrle_dp #(
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.row_load       (row_load),
		.row_load_value (row_load_value),
		.data_byte      (data_in.data_byte),
		.cmd            (cmd),
		.st             (st),
		.out_ready      (pixel_out.ready),
		.out_valid      (pixel_out.valid),
		.pixel_address  (pixel_out.pixel_address),
		.pixel_value    (pixel_out.pixel_value),
		.last_of_item   (pixel_out.last_of_item),
		.image_done     (pixel_out.image_done)
	);

endmodule

`default_nettype wire

### rtl/pcxrle_cfg.sv
// APB register file of the PCX RLE decoder: image limits, frame size, start row.
// Depends on pcxrle_pkg. A start_row write also reloads the row counter.
`default_nettype none

module pcxrle_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pcxrle_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pcxrle_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [pcxrle_pkg::APB_DATA_W-1:0] prdata,
	output logic                                   pready,
	output pcxrle_pkg::cfg_t                       cfg,
	output logic                                   row_load,
	output logic      [pcxrle_pkg::START_W-1:0]    row_load_value
);
	import pcxrle_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.last_column  <= LIM_W'(319);
			cfg_q.last_row     <= LIM_W'(199);
			cfg_q.line_width   <= SIZE_W'(352);
			cfg_q.frame_height <= SIZE_W'(727);
			cfg_q.start_row    <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_LAST_COLUMN:  cfg_q.last_column  <= pwdata[LIM_W-1:0];
				REG_LAST_ROW:     cfg_q.last_row     <= pwdata[LIM_W-1:0];
				REG_LINE_WIDTH:   cfg_q.line_width   <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[SIZE_W-1:0];
				REG_START_ROW:    cfg_q.start_row    <= pwdata[START_W-1:0];
				default: ;
			endcase
		end
	end

	assign row_load       = wr_en && (idx == REG_START_ROW);
	assign row_load_value = pwdata[START_W-1:0];
	assign cfg            = cfg_q;

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_LAST_COLUMN:  prdata = APB_DATA_W'(cfg_q.last_column);
			REG_LAST_ROW:     prdata = APB_DATA_W'(cfg_q.last_row);
			REG_LINE_WIDTH:   prdata = APB_DATA_W'(cfg_q.line_width);
			REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_q.frame_height);
			REG_START_ROW:    prdata = APB_DATA_W'(cfg_q.start_row);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/pcxrle_ctrl.sv
// Control state machine of the PCX RLE decoder: input handshake and run sequencing.
// Depends on pcxrle_pkg; drives pcxrle_dp through dp_cmd_t.
`default_nettype none

module pcxrle_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire pcxrle_pkg::dp_status_t st,
	output pcxrle_pkg::dp_cmd_t         cmd
);
	import pcxrle_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				// after the end of the image bytes are swallowed; run data needs no slot
				in_ready = st.finished | st.pending | st.slot_free;
				if (in_valid && in_ready && !st.finished) begin
					if (st.pending) begin
						cmd.load_run = 1'b1;
						if (st.run_zero)
							cmd.check = 1'b1;
						else
							state_d = ST_RUN;
					end else if (st.header) begin
						cmd.set_pending = 1'b1;
					end else begin
						cmd.emit = 1'b1;
						cmd.last = 1'b1;
					end
				end
			end
			ST_RUN: begin
				if (st.slot_free) begin
					cmd.emit     = 1'b1;
					cmd.from_run = 1'b1;
					if (st.run_one) begin
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### rtl/pcxrle_dp.sv
// Datapath of the PCX RLE decoder: column/row counters, run count, address
// multiply-add, limit checks and the output register. Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_dp #(
	parameter int ADDR_BITS = 20
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pcxrle_pkg::cfg_t                  cfg,
	input  wire logic                              row_load,
	input  wire logic [pcxrle_pkg::START_W-1:0]    row_load_value,
	input  wire logic [pcxrle_pkg::BYTE_W-1:0]     data_byte,
	input  wire pcxrle_pkg::dp_cmd_t               cmd,
	output pcxrle_pkg::dp_status_t                 st,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic      [pcxrle_pkg::PIX_ADDR_W-1:0] pixel_address,
	output logic      [pcxrle_pkg::BYTE_W-1:0]     pixel_value,
	output logic                                   last_of_item,
	output logic                                   image_done
);
	import pcxrle_pkg::*;

	localparam logic [SUM_W-1:0] ADDR_MASK = SUM_W'((64'd1 << ADDR_BITS) - 64'd1);

	logic [COL_W-1:0]      column_q;
	logic [ROW_W-1:0]      row_q;
	logic                  pending_q;
	logic [RUN_W-1:0]      run_q;
	logic                  finished_q;
	logic [BYTE_W-1:0]     value_q;
	logic                  out_valid_q;
	logic [PIX_ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0]     pix_q;
	logic                  last_q;
	logic                  done_q;

	logic [LIM_W-1:0]  col_lim;
	logic [LIM_W-1:0]  row_lim;
	logic [COL_W-1:0]  col_next;
	logic              wrap;
	logic [ROW_W-1:0]  row_next;
	logic [COL_W-1:0]  col_after;
	logic [ROW_W-1:0]  row_off;
	logic              fin_next;
	logic              check_now;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  addr_sum;

	assign col_lim = clamp_limit(cfg.last_column, cfg.line_width);
	assign row_lim = clamp_limit(cfg.last_row, cfg.frame_height);

	// column value after this pixel, then end-of-item wrap and end check
	assign col_next  = cmd.emit ? column_q + COL_W'(1) : column_q;
	assign wrap      = col_next > {{(COL_W-LIM_W){1'b0}}, col_lim};
	assign row_next  = wrap ? row_q + ROW_W'(1) : row_q;
	assign col_after = wrap ? '0 : col_next;
	assign row_off   = row_next - {{(ROW_W-START_W){1'b0}}, cfg.start_row};
	assign fin_next  = {{(LIM_W-ROW_W){1'b0}}, row_off} > row_lim;
	assign check_now = cmd.last | cmd.check;

	assign prod     = PROD_W'(row_q) * PROD_W'(cfg.line_width);
	assign addr_sum = ({{(SUM_W-PROD_W){1'b0}}, prod} + {{(SUM_W-COL_W){1'b0}}, column_q})
		& ADDR_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			row_q      <= '0;
			pending_q  <= 1'b0;
			run_q      <= '0;
			finished_q <= 1'b0;
		end else begin
			if (row_load)
				row_q <= {{(ROW_W-START_W){1'b0}}, row_load_value};
			else if (check_now)
				row_q <= row_next;

			if (check_now) begin
				column_q   <= col_after;
				finished_q <= fin_next;
			end else if (cmd.emit) begin
				column_q <= col_next;
			end

			if (cmd.set_pending) begin
				pending_q <= 1'b1;
				run_q     <= data_byte[RUN_W-1:0] & RUN_MASK[RUN_W-1:0];
			end else if (cmd.load_run) begin
				pending_q <= 1'b0;
			end else if (cmd.emit && cmd.from_run) begin
				run_q <= run_q - RUN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_run)
			value_q <= data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			addr_q <= addr_sum[PIX_ADDR_W-1:0];
			pix_q  <= cmd.from_run ? value_q : data_byte;
			last_q <= cmd.last;
			done_q <= cmd.last & fin_next;
		end
	end

	assign st.finished  = finished_q;
	assign st.pending   = pending_q;
	assign st.header    = is_run_header(data_byte);
	assign st.run_zero  = run_q == '0;
	assign st.run_one   = run_q == RUN_W'(1);
	assign st.slot_free = !out_valid_q | out_ready;

	assign out_valid     = out_valid_q;
	assign pixel_address = addr_q;
	assign pixel_value   = pix_q;
	assign last_of_item  = last_q;
	assign image_done    = done_q;

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench for pcx_rle_pixel_decoder: directed and random PCX byte streams, APB register
// setup between images, and a scoreboard that predicts every frame buffer pixel write.
// Depends on pcxrle_pkg, pcxrle_byte_if, pcxrle_pix_if and the decoder RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcxrle_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_PCT      = 18;
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int TAIL_CYCLES   = 20;

	typedef struct packed {
		logic [PIX_ADDR_W-1:0] pixel_address;
		logic [BYTE_W-1:0]     pixel_value;
		logic                  last_of_item;
		logic                  image_done;
	} pixel_t;

	class rle_frame_model;
		logic [LIM_W-1:0]   last_column;
		logic [LIM_W-1:0]   last_row;
		logic [SIZE_W-1:0]  line_width;
		logic [SIZE_W-1:0]  frame_height;
		logic [START_W-1:0] start_row;

		logic [COL_W-1:0]   column;
		logic [ROW_W-1:0]   row;
		bit                 run_pending;
		logic [RUN_W-1:0]   run_length;
		bit                 finished;

		pixel_t frame_writes[$];
		int bytes_taken, bytes_dropped, runs_seen, empty_runs;
		int pixels_checked, mismatches;

		function new();
			last_column  = LIM_W'(319);
			last_row     = LIM_W'(199);
			line_width   = SIZE_W'(352);
			frame_height = SIZE_W'(727);
			start_row    = '0;
			column       = '0;
			row          = '0;
			run_pending  = 1'b0;
			run_length   = '0;
			finished     = 1'b0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
			case (idx)
				REG_LAST_COLUMN:  last_column = value[LIM_W-1:0];
				REG_LAST_ROW:     last_row = value[LIM_W-1:0];
				REG_LINE_WIDTH:   line_width = value[SIZE_W-1:0];
				REG_FRAME_HEIGHT: frame_height = value[SIZE_W-1:0];
				REG_START_ROW: begin
					start_row = value[START_W-1:0];
					row = ROW_W'(start_row);
				end
				default: ;
			endcase
		endfunction

		// a zero size gives -1 on the right, so the limit drops to zero
		function int limit_of(logic [LIM_W-1:0] hi, logic [SIZE_W-1:0] size);
			int lim, sz;
			lim = int'(hi);
			sz = int'(size);
			if (lim > sz - 1)
				lim = sz;
			return lim;
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b);
			pixel_t batch[$];
			pixel_t px;
			logic [31:0] lin;
			logic [ROW_W-1:0] offset;
			int n_pix, k, col_i, offset_i, col_lim, row_lim;
			if (finished) begin
				bytes_dropped++;
				return;
			end
			bytes_taken++;
			if (run_pending) begin
				n_pix = int'(run_length);
				runs_seen++;
				if (run_length == '0)
					empty_runs++;
				run_pending = 1'b0;
				run_length = '0;
			end else if ((b & RUN_MARK) == RUN_MARK) begin
				run_pending = 1'b1;
				run_length = b[RUN_W-1:0];
				return;
			end else begin
				n_pix = 1;
			end
			for (k = 0; k < n_pix; k++) begin
				lin = 32'(row) * 32'(line_width) + 32'(column);
				px.pixel_address = lin[PIX_ADDR_W-1:0];
				px.pixel_value = b;
				px.last_of_item = 1'b0;
				px.image_done = 1'b0;
				batch.push_back(px);
				column = column + COL_W'(1);
			end
			// wrap and end checks only once the whole item is done
			col_lim = limit_of(last_column, line_width);
			row_lim = limit_of(last_row, frame_height);
			col_i = int'(column);
			if (col_i > col_lim) begin
				column = '0;
				row = row + ROW_W'(1);
			end
			offset = row - ROW_W'(start_row);
			offset_i = int'(offset);
			if (offset_i > row_lim)
				finished = 1'b1;
			if (batch.size() > 0) begin
				batch[batch.size()-1].last_of_item = 1'b1;
				batch[batch.size()-1].image_done = finished;
			end
			foreach (batch[i])
				frame_writes.push_back(batch[i]);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			pixels_checked++;
			if (frame_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: pixel with none expected: addr %h value %h last %b done %b",
						$time, got.pixel_address, got.pixel_value, got.last_of_item,
						got.image_done);
				return;
			end
			want = frame_writes.pop_front();
			if (got.pixel_address !== want.pixel_address || got.pixel_value !== want.pixel_value ||
					got.last_of_item !== want.last_of_item ||
					got.image_done !== want.image_done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: pixel mismatch: expected addr %h value %h last %b done %b, %s",
						$time, want.pixel_address, want.pixel_value, want.last_of_item,
						want.image_done, $sformatf("got addr %h value %h last %b done %b",
						got.pixel_address, got.pixel_value, got.last_of_item, got.image_done));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pcxrle_byte_if byte_ch ();
	pcxrle_pix_if  pix_ch ();

	rle_frame_model decoder_model;
	bit no_idle;
	bit stall_req;
	int hold_left;
	int cycles_run;
	int reg_writes;

	pcx_rle_pixel_decoder #(.ADDR_BITS(20)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_in   (byte_ch),
		.pixel_out (pix_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still expected", cycles_run,
				decoder_model.frame_writes.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// pixel receiver: random back-pressure, plus one long hold on request
	initial begin
		pix_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pix_ch.ready <= 1'b0;
				hold_left--;
			end else if (stall_req) begin
				stall_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : pixel_monitor
		pixel_t got;
		if (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
			got = {pix_ch.pixel_address, pix_ch.pixel_value, pix_ch.last_of_item,
				pix_ch.image_done};
			decoder_model.check_pixel(got);
		end
	end

	// all driving tasks start and end on a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do
			@(posedge clk);
		while (byte_ch.ready !== 1'b1);
		decoder_model.take_byte(b);
		@(negedge clk);
	endtask

	task automatic send_run(input logic [RUN_W-1:0] len, input logic [BYTE_W-1:0] value);
		send_byte(RUN_MARK | {2'b00, len});
		send_byte(value);
	endtask

	// psel stays high across back-to-back writes; the caller drops it
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		decoder_model.set_reg(idx, value);
		reg_writes++;
		@(negedge clk);
	endtask

	// empty runs give no pixel, so wait SETTLE_CYCLES more after the last one
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (decoder_model.frame_writes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic program_image(input int lc, input int lr, input int lw, input int fh,
			input int sr);
		settle();
		write_reg(REG_LAST_COLUMN, lc);
		write_reg(REG_LAST_ROW, lr);
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_FRAME_HEIGHT, fh);
		write_reg(REG_START_ROW, sr);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// row limit kept at 64 or more, so a phase never ends the image
	task automatic random_image();
		int lc, lw, fh, pick;
		pick = $urandom_range(9);
		lw = (pick == 0) ? 1 : (pick == 1) ? 2047 : $urandom_range(1, 1024);
		pick = $urandom_range(9);
		lc = (pick == 0) ? 32767 : (pick == 1) ? 0 : $urandom_range(0, 40);
		fh = $urandom_range(64, 2047);
		program_image(lc, $urandom_range(64, 32767), lw, fh, $urandom_range(0, 1023));
	endtask

	task automatic random_stream(input int count);
		int sent, pick;
		logic [RUN_W-1:0] len;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_byte(BYTE_W'($urandom_range(0, 8'hBF)));
				sent++;
			end else if (pick < 90) begin
				pick = $urandom_range(9);
				len = RUN_W'((pick == 0) ? 0 : (pick < 8) ? $urandom_range(1, 16) :
					$urandom_range(17, 63));
				send_run(len, BYTE_W'($urandom_range(255)));
				sent += 2;
			end else begin
				send_byte(BYTE_W'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		decoder_model = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: literals at the byte extremes, runs of 1, 63, 0 and 5
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(8'hBF);
		send_byte(8'h40);
		send_run(6'd1, 8'hFF);
		send_run(6'd63, 8'hC0);
		send_run(6'd0, 8'h55);
		send_run(6'd5, 8'h00);

		// widest frame, top start row: address wraps, long runs spill past the line end
		program_image(5, 32767, 2047, 2047, 1023);
		send_run(6'd8, 8'h11);
		send_byte(8'h3F);
		send_byte(8'hAA);
		send_run(6'd63, 8'h01);

		// zero line width: every item wraps the column
		program_image(32767, 32767, 0, 2047, 0);
		send_byte(8'h12);
		send_byte(8'h34);
		send_run(6'd3, 8'hEE);

		for (int p = 0; p < 5; p++) begin
			random_image();
			no_idle = (p == 1);
			if (p == 2)
				stall_req = 1'b1;
			random_stream(36);
		end
		no_idle = 1'b0;

		// zero frame height: the image ends at the first wrap, the rest is dropped
		program_image(3, $urandom_range(0, 32767), $urandom_range(4, 2047), 0,
			$urandom_range(0, 1023));
		repeat (4) send_byte(BYTE_W'($urandom_range(0, 8'hBF)));
		random_stream(16);

		byte_ch.valid <= 1'b0;
		waited = 0;
		while (decoder_model.frame_writes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Decoded %0d bytes (%0d runs, %0d empty) into %0d pixels over %0d reg writes;",
			decoder_model.bytes_taken, decoder_model.runs_seen, decoder_model.empty_runs,
			decoder_model.pixels_checked, reg_writes);
		$display("image end reached: %0b, %0d bytes dropped after it, %0d mismatches.",
			decoder_model.finished, decoder_model.bytes_dropped, decoder_model.mismatches);
		if (decoder_model.frame_writes.size() != 0)
			$display("%0d expected pixels never arrived", decoder_model.frame_writes.size());
		if (decoder_model.mismatches == 0 && decoder_model.frame_writes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
